>>> rtl/lwtb_pkg.sv
// Shared constants, types and control/status bundles for the layered transform blend.
package lwtb_pkg;

  localparam int NUM_CH     = 8;   // transform channels per track
  localparam int DATA_W     = 32;  // signed Q16.16
  localparam int WGT_W      = 17;  // unsigned Q1.16
  localparam int LAYER_W    = 8;
  localparam int CNT_W      = 4;   // holds NUM_CH
  localparam int S_TDATA_W  = 288;
  localparam int M_TDATA_W  = 280;

  localparam logic [WGT_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [WGT_W-1:0] SUM_MAX = 17'h1FFFF;

  // channel slots
  localparam int CH_SCALE_X = 4;
  localparam int CH_SCALE_Y = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_WEIGHT = 5'b00100,
    ST_MAC    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic weight;
    logic sum_add;
    logic mult;
    logic acc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic contrib;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [LAYER_W-1:0]     layer;
    logic [WGT_W-1:0]       current_weight;
    logic                   blend_enabled;
    word_t [NUM_CH-1:0]     vals;   // pos x/y, skew x/y, scale x/y, pivot x/y
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [WGT_W-1:0]       effective_weight;
    word_t [NUM_CH-1:0]     vals;
    logic                   done_res;
  } result_t;

endpackage

>>> rtl/lwtb_ctrl.sv
// Sequencer for the blend: check, weight, channel MAC loop, result hand-off.
module lwtb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lwtb_pkg::sts_t  sts,
  output lwtb_pkg::cmd_t  cmd
);

  lwtb_pkg::state_t              state, state_next;
  logic [lwtb_pkg::CNT_W-1:0]    cnt, cnt_next;

  localparam logic [lwtb_pkg::CNT_W-1:0] CNT_END = lwtb_pkg::CNT_W'(lwtb_pkg::NUM_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwtb_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lwtb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = lwtb_pkg::ST_CHECK;
        end
      end
      lwtb_pkg::ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = lwtb_pkg::ST_WEIGHT;
      end
      lwtb_pkg::ST_WEIGHT: begin
        cmd.weight = 1'b1;
        cnt_next   = '0;
        state_next = lwtb_pkg::ST_MAC;
      end
      lwtb_pkg::ST_MAC: begin
        if (!sts.contrib) begin
          state_next = lwtb_pkg::ST_FIN;
        end else begin
          cmd.sum_add = (cnt == '0);
          cmd.mult    = (cnt != CNT_END);
          cmd.acc     = (cnt != '0);
          cnt_next    = cnt + 1'b1;
          if (cnt == CNT_END) begin
            state_next = lwtb_pkg::ST_FIN;
          end
        end
      end
      lwtb_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = lwtb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lwtb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lwtb_datapath.sv
// Weight budget, shared multiplier, saturating accumulators and result register.
module lwtb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lwtb_pkg::item_t     item,
  input  lwtb_pkg::cmd_t      cmd,
  output lwtb_pkg::sts_t      sts,
  input  logic                res_ready,
  output logic                res_valid,
  output lwtb_pkg::result_t   res
);

  localparam int VW = lwtb_pkg::DATA_W + 1;          // value less scale offset
  localparam int PW = VW + lwtb_pkg::WGT_W + 1;      // signed product
  localparam int AW = lwtb_pkg::DATA_W + 4;          // accumulate headroom

  localparam logic signed [lwtb_pkg::DATA_W-1:0] S_MAX = {1'b0, {(lwtb_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [lwtb_pkg::DATA_W-1:0] S_MIN = {1'b1, {(lwtb_pkg::DATA_W-1){1'b0}}};

  // captured item
  logic [lwtb_pkg::LAYER_W-1:0]  layer_r;
  logic [lwtb_pkg::WGT_W-1:0]    cw_r;
  logic                          en_r;
  logic                          last_r;
  logic signed [VW-1:0]          vals [lwtb_pkg::NUM_CH];

  // run state
  logic [lwtb_pkg::WGT_W-1:0]    budget;
  logic [lwtb_pkg::WGT_W-1:0]    lsum;
  logic [lwtb_pkg::LAYER_W-1:0]  prev_layer;
  logic                          run_start;
  logic                          stopped;
  logic                          contrib;
  lwtb_pkg::word_t               acc [lwtb_pkg::NUM_CH];

  logic [lwtb_pkg::WGT_W-1:0]    weight;
  logic signed [PW-1:0]          prod;

  logic [2*lwtb_pkg::WGT_W-1:0]  wprod;
  logic [lwtb_pkg::WGT_W-1:0]    wcalc;
  logic [lwtb_pkg::WGT_W:0]      sum_wide;
  logic [lwtb_pkg::WGT_W-1:0]    lsum_next;
  logic signed [AW-1:0]          acc_wide;
  lwtb_pkg::word_t               acc_next;

  // scale deviation back to absolute, saturating upward
  function automatic lwtb_pkg::word_t sat_one(input lwtb_pkg::word_t a);
    logic signed [lwtb_pkg::DATA_W:0] s;
    s = {a[lwtb_pkg::DATA_W-1], a} + (lwtb_pkg::DATA_W+1)'(lwtb_pkg::ONE_Q16);
    if (s[lwtb_pkg::DATA_W] != s[lwtb_pkg::DATA_W-1]) begin
      sat_one = S_MAX;
    end else begin
      sat_one = s[lwtb_pkg::DATA_W-1:0];
    end
  endfunction

  assign wprod = cw_r * budget;
  assign wcalc = wprod[lwtb_pkg::WGT_W+15:16];

  assign sum_wide  = {1'b0, lsum} + {1'b0, weight};
  assign lsum_next = sum_wide[lwtb_pkg::WGT_W] ? lwtb_pkg::SUM_MAX
                                               : sum_wide[lwtb_pkg::WGT_W-1:0];

  // floor(prod / 65536) is the arithmetic shift
  assign acc_wide = {{(AW-lwtb_pkg::DATA_W){acc[0][lwtb_pkg::DATA_W-1]}}, acc[0]}
                  + {prod[PW-1], prod[PW-1:16]};

  always_comb begin
    if (acc_wide > AW'(S_MAX)) begin
      acc_next = S_MAX;
    end else if (acc_wide < AW'(S_MIN)) begin
      acc_next = S_MIN;
    end else begin
      acc_next = acc_wide[lwtb_pkg::DATA_W-1:0];
    end
  end

  assign sts.contrib  = contrib;
  assign sts.out_free = !res_valid || res_ready;

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      layer_r <= item.layer;
      cw_r    <= (item.current_weight > lwtb_pkg::ONE_Q16) ? lwtb_pkg::ONE_Q16
                                                          : item.current_weight;
      en_r    <= item.blend_enabled;
      last_r  <= item.last;
      for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
        vals[i] <= {item.vals[i][lwtb_pkg::DATA_W-1], item.vals[i]}
                 - (((i == lwtb_pkg::CH_SCALE_X) || (i == lwtb_pkg::CH_SCALE_Y))
                    ? VW'(lwtb_pkg::ONE_Q16) : VW'(0));
      end
    end else if (cmd.mult) begin
      for (int i = 0; i < lwtb_pkg::NUM_CH - 1; i++) begin
        vals[i] <= vals[i+1];
      end
    end
    if (cmd.weight) begin
      weight <= stopped ? '0 : wcalc;
    end
    if (cmd.mult) begin
      prod <= vals[0] * $signed({1'b0, weight});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.effective_weight <= weight;
      res.done_res         <= last_r;
      for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
        if (!last_r) begin
          res.vals[i] <= '0;
        end else if ((i == lwtb_pkg::CH_SCALE_X) || (i == lwtb_pkg::CH_SCALE_Y)) begin
          res.vals[i] <= sat_one(acc[i]);
        end else begin
          res.vals[i] <= acc[i];
        end
      end
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      budget     <= lwtb_pkg::ONE_Q16;
      lsum       <= '0;
      prev_layer <= '0;
      run_start  <= 1'b1;
      stopped    <= 1'b0;
      contrib    <= 1'b0;
      res_valid  <= 1'b0;
      for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
        acc[i] <= '0;
      end
    end else begin
      // layer change: spend the budget or stop the run
      if (cmd.check && !stopped && !run_start && (layer_r != prev_layer)) begin
        if (lsum >= budget) begin
          stopped <= 1'b1;
        end else begin
          budget <= budget - lsum;
        end
      end
      if (cmd.weight) begin
        run_start <= 1'b0;
        if (!stopped) begin
          prev_layer <= layer_r;
        end
        contrib <= !stopped && (wcalc != '0) && (en_r || (run_start && last_r));
      end
      if (cmd.sum_add) begin
        lsum <= lsum_next;
      end
      // rotate so acc[0] always faces the product in flight
      if (cmd.acc) begin
        for (int i = 0; i < lwtb_pkg::NUM_CH - 1; i++) begin
          acc[i] <= acc[i+1];
        end
        acc[lwtb_pkg::NUM_CH-1] <= acc_next;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd.load_out && last_r) begin
        budget     <= lwtb_pkg::ONE_Q16;
        lsum       <= '0;
        prev_layer <= '0;
        run_start  <= 1'b1;
        stopped    <= 1'b0;
        for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
          acc[i] <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/layered_weighted_transform_blend.sv
// Top level of the layered weighted transform blend: stream ports, controller and datapath.
// A skipped track (weight 0, disabled unless it is alone in its bone, or budget used up) skips
//   the channel MAC loop, so its result is offered sooner than that of a contributing track.
// One track is in work at a time, and a track stalls before its result is loaded while the
//   previous result waits on m_tready; one shared 33x18 multiplier takes a channel per cycle.
// Reset (rst, synchronous, active high): budget back to one, accumulators cleared, no result held.
module layered_weighted_transform_blend (
  input  logic                              clk,
  input  logic                              rst,
  // input track
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // layer, current_weight, pos_x, pos_y, skew_x, skew_y, scale_x, scale_y,
  // pivot_x, pivot_y, zero pad
  input  logic [lwtb_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,   // blend_enabled
  input  logic                              s_tlast,   // last track of the bone
  // result
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // effective_weight, out_x, out_y, out_skew_x, out_skew_y, out_scale_x,
  // out_scale_y, out_pivot_x, out_pivot_y, zero pad
  output logic [lwtb_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tlast    // done_res
);

  localparam int IN_VAL_LSB  = lwtb_pkg::LAYER_W + lwtb_pkg::WGT_W;
  localparam int OUT_VAL_LSB = lwtb_pkg::WGT_W;

  lwtb_pkg::item_t    item;
  lwtb_pkg::result_t  res;
  lwtb_pkg::cmd_t     cmd;
  lwtb_pkg::sts_t     sts;

  // unpack the incoming transaction
  always_comb begin
    item.layer          = s_tdata[lwtb_pkg::LAYER_W-1:0];
    item.current_weight = s_tdata[lwtb_pkg::LAYER_W +: lwtb_pkg::WGT_W];
    item.blend_enabled  = s_tuser;
    item.last           = s_tlast;
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
      item.vals[i] = s_tdata[IN_VAL_LSB + i*lwtb_pkg::DATA_W +: lwtb_pkg::DATA_W];
    end
  end

  // pack the outgoing transaction; pad bits stay zero
  always_comb begin
    m_tdata = '0;
    m_tdata[lwtb_pkg::WGT_W-1:0] = res.effective_weight;
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
      m_tdata[OUT_VAL_LSB + i*lwtb_pkg::DATA_W +: lwtb_pkg::DATA_W] = res.vals[i];
    end
  end

  assign m_tlast = res.done_res;

  lwtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lwtb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .res_ready (m_tready),
    .res_valid (m_tvalid),
    .res       (res)
  );

endmodule

>>> rtl/lwtb_checker.sv
// Port-level checks for the layered transform blend, bound to the top level.
module lwtb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lwtb_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                              m_tlast
);

  localparam int BLEND_MSB = lwtb_pkg::WGT_W + lwtb_pkg::NUM_CH * lwtb_pkg::DATA_W - 1;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // blended fields only on the final track of a bone
  a_zero_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[BLEND_MSB:lwtb_pkg::WGT_W] == '0)
    else $error("blended fields nonzero before last track");

  // applied weight never exceeds one
  a_weight: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[lwtb_pkg::WGT_W-1:0] <= lwtb_pkg::ONE_Q16)
    else $error("effective weight above one");

  // one track in work at a time
  a_one_trk: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind layered_weighted_transform_blend lwtb_checker u_lwtb_checker (.*);

>>> sim/tb_layered_weighted_transform_blend.sv
// Self-checking testbench for the layered weighted transform blend.
`timescale 1ns / 100ps

module tb_layered_weighted_transform_blend;

  // Run shape
  localparam int RAND_TRACKS  = 530;   // random tracks after the directed table
  localparam int SINK_HOLD    = 400;   // one long back-pressure stretch on the result side
  localparam int DRAIN_CYCLES = 40;    // quiet wait after the last expected result, to catch stray transactions
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [lwtb_pkg::S_TDATA_W-1:0]   s_tdata;
  logic                             s_tuser;
  logic                             s_tlast;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [lwtb_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                             m_tlast;

  layered_weighted_transform_blend dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One row of the directed table. Where "typed" is set, the expected result is
  // written out by hand; otherwise the blend predictor supplies it.
  typedef struct {
    lwtb_pkg::item_t   trk;
    bit                typed;
    lwtb_pkg::result_t res;
  } script_row_t;

  string ch_names [lwtb_pkg::NUM_CH] = '{"out_x", "out_y", "out_skew_x", "out_skew_y",
                                         "out_scale_x", "out_scale_y", "out_pivot_x",
                                         "out_pivot_y"};

  // Predictor state: mirrors the bone's blend state between tracks.
  logic [lwtb_pkg::WGT_W-1:0]   budget;       // weight left for lower layers, Q1.16
  logic [lwtb_pkg::WGT_W-1:0]   layer_total;  // running sum of applied weights, cleared at the end of each bone
  logic [lwtb_pkg::LAYER_W-1:0] prior_layer;
  bit                           run_first;    // next track opens a new bone
  bit                           run_halted;   // budget used up: rest of the bone gets weight 0
  lwtb_pkg::word_t              acc [lwtb_pkg::NUM_CH];  // scale slots hold deviation from one

  script_row_t       script [$];         // directed table
  lwtb_pkg::result_t pending_blends [$]; // expected results, oldest first
  int      mismatches = 0;
  bit      hold_sink = 1'b0;         // request for the long result-side stall
  bit      sink_steady = 1'b0;       // stretch with the receiver always ready
  bit      src_steady = 1'b0;        // stretch with the sender never idling

  function automatic lwtb_pkg::word_t clamp32(longint s);
    if (s > WORD_MAX) return lwtb_pkg::word_t'(WORD_MAX);
    if (s < WORD_MIN) return lwtb_pkg::word_t'(WORD_MIN);
    return lwtb_pkg::word_t'(s);
  endfunction

  function automatic void clear_bone();
    budget      = lwtb_pkg::ONE_Q16;
    layer_total = '0;
    prior_layer = '0;
    run_first   = 1'b1;
    run_halted  = 1'b0;
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++) acc[i] = '0;
  endfunction

  // Blend predictor: advances the bone state by one track and returns the
  // result transaction the block should produce for it.
  function automatic lwtb_pkg::result_t blend_track(lwtb_pkg::item_t t);
    lwtb_pkg::result_t          r;
    logic [lwtb_pkg::WGT_W-1:0] cw;
    logic [lwtb_pkg::WGT_W-1:0] w;
    logic [33:0]                prod;
    longint                     v;
    int                         sum_w;
    bit                         lone;
    r    = '0;
    w    = '0;
    lone = run_first && t.last;
    cw   = (t.current_weight > lwtb_pkg::ONE_Q16) ? lwtb_pkg::ONE_Q16 : t.current_weight;
    // layer change: either the budget is gone or it shrinks by the running total
    if (!run_halted && !run_first && t.layer != prior_layer) begin
      if (layer_total >= budget) run_halted = 1'b1;
      else budget = budget - layer_total;
    end
    if (!run_halted) begin
      prior_layer = t.layer;
      prod = cw * budget;
      w = prod[32:16];
      // a lone track blends regardless of its enable flag
      if (w != 0 && (t.blend_enabled || lone)) begin
        for (int i = 0; i < lwtb_pkg::NUM_CH; i++) begin
          v = $signed(t.vals[i]);
          if (i == lwtb_pkg::CH_SCALE_X || i == lwtb_pkg::CH_SCALE_Y) v = v - 65536;
          acc[i] = clamp32(longint'(acc[i]) + ((v * longint'(w)) >>> 16));
        end
        sum_w = int'(layer_total) + int'(w);
        layer_total = (sum_w > int'(lwtb_pkg::SUM_MAX)) ? lwtb_pkg::SUM_MAX
                                                         : sum_w[lwtb_pkg::WGT_W-1:0];
      end
    end
    run_first = 1'b0;
    r.effective_weight = w;
    if (t.last) begin
      for (int i = 0; i < lwtb_pkg::NUM_CH; i++)
        r.vals[i] = (i == lwtb_pkg::CH_SCALE_X || i == lwtb_pkg::CH_SCALE_Y) ?
                    clamp32(longint'(acc[i]) + 65536) : acc[i];
      r.done_res = 1'b1;
      clear_bone();
    end
    return r;
  endfunction

  function automatic logic [lwtb_pkg::S_TDATA_W-1:0] pack_track(lwtb_pkg::item_t t);
    logic [lwtb_pkg::S_TDATA_W-1:0] d;
    d = '0;
    d[lwtb_pkg::LAYER_W-1:0]               = t.layer;
    d[lwtb_pkg::LAYER_W +: lwtb_pkg::WGT_W] = t.current_weight;
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++)
      d[lwtb_pkg::LAYER_W + lwtb_pkg::WGT_W + lwtb_pkg::DATA_W*i +: lwtb_pkg::DATA_W] =
        t.vals[i];
    return d;
  endfunction

  // Directed track: all eight channels carry the same value.
  function automatic lwtb_pkg::item_t trk(int lyr, int cw, bit en, bit lst,
                                          lwtb_pkg::word_t val);
    lwtb_pkg::item_t t;
    t = '0;
    t.layer          = lyr[lwtb_pkg::LAYER_W-1:0];
    t.current_weight = cw[lwtb_pkg::WGT_W-1:0];
    t.blend_enabled  = en;
    t.last           = lst;
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++) t.vals[i] = val;
    return t;
  endfunction

  // Hand-written result: position/skew/pivot channels = v, scale channels = sv.
  function automatic lwtb_pkg::result_t bone_out(int w, lwtb_pkg::word_t v,
                                                 lwtb_pkg::word_t sv, bit dn);
    lwtb_pkg::result_t r;
    r = '0;
    r.effective_weight = w[lwtb_pkg::WGT_W-1:0];
    for (int i = 0; i < lwtb_pkg::NUM_CH; i++)
      r.vals[i] = (i == lwtb_pkg::CH_SCALE_X || i == lwtb_pkg::CH_SCALE_Y) ? sv : v;
    r.done_res = dn;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(lwtb_pkg::item_t t, bit typed, lwtb_pkg::result_t r);
    script_row_t row;
    row.trk   = t;
    row.typed = typed;
    row.res   = r;
    script.insert(script.size(), row);
  endfunction

  function automatic lwtb_pkg::word_t rand_word();
    case ($urandom_range(9))
      0:       return lwtb_pkg::word_t'(WORD_MAX);
      1:       return lwtb_pkg::word_t'(WORD_MIN);
      2, 3, 4: return lwtb_pkg::word_t'($urandom);
      // scale near one
      5:       return lwtb_pkg::word_t'(65536 + int'($urandom_range(8192)) - 4096);
      // within +/-16.0
      default: return lwtb_pkg::word_t'(int'($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic int rand_weight();
    int r;
    r = $urandom_range(19);
    if (r == 0)      return 0;
    else if (r <= 4) return 65536;
    else if (r <= 6) return $urandom_range(131071, 65537);  // above one, gets clamped
    else if (r <= 8) return $urandom_range(255);
    else             return $urandom_range(65536);
  endfunction

  // Offer one track, wait for its transaction, then record the expected result.
  task automatic send_track(lwtb_pkg::item_t t, bit typed, lwtb_pkg::result_t res);
    int                gap;
    int                r;
    lwtb_pkg::result_t predicted;
    gap = 0;
    if (!src_steady) begin
      r = $urandom_range(99);
      if (r >= 92)      gap = $urandom_range(30, 5);
      else if (r >= 60) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_track(t);
    s_tuser  <= t.blend_enabled;
    s_tlast  <= t.last;
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = blend_track(t);
    pending_blends.insert(pending_blends.size(), typed ? res : predicted);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %08h, actual %08h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: every accepted transaction is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    lwtb_pkg::result_t want;
    lwtb_pkg::result_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got.effective_weight = m_tdata[lwtb_pkg::WGT_W-1:0];
      for (int i = 0; i < lwtb_pkg::NUM_CH; i++)
        got.vals[i] = m_tdata[lwtb_pkg::WGT_W + lwtb_pkg::DATA_W*i +: lwtb_pkg::DATA_W];
      got.done_res = m_tlast;
      if (pending_blends.size() == 0) begin
        $error("result transaction with nothing pending: tdata=%h tlast=%b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_blends.pop_front();
        check_field("effective_weight", 32'(want.effective_weight),
                    32'(got.effective_weight));
        for (int i = 0; i < lwtb_pkg::NUM_CH; i++)
          check_field(ch_names[i], want.vals[i], got.vals[i]);
        check_field("done_res", 32'(want.done_res), 32'(got.done_res));
      end
    end
  end

  // Receiver: mostly ready, short and occasional long stalls, steady stretches,
  // and one long hold-off so the block backs up into its input side.
  initial begin : sink
    int n;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
      end else if (sink_steady || $urandom_range(3) != 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    int idle_cycles;
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    lwtb_pkg::item_t t;
    int              sent;
    int              run_len;
    int              lyr;
    int              cw_pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    clear_bone();

    // Lone tracks: full weight, zero weight, over-range weight with blending off
    add_row(trk(9, 65536, 1, 1, 32'h0003_0000), 1,
            bone_out(65536, 32'h0003_0000, 32'h0003_0000, 1));
    add_row(trk(0, 0, 1, 1, 32'h7FFF_FFFF), 1, bone_out(0, 0, 32'h0001_0000, 1));
    add_row(trk(255, 131071, 0, 1, 32'h0001_0000), 1,
            bone_out(65536, 32'h0001_0000, 32'h0001_0000, 1));
    // First layer takes the whole budget, so both lower tracks are skipped
    add_row(trk(200, 65536, 1, 0, 32'h0002_0000), 1, bone_out(65536, 0, 0, 0));
    add_row(trk(100, 65536, 1, 0, 32'h7FFF_FFFF), 1, bone_out(0, 0, 0, 0));
    add_row(trk(50, 40000, 1, 1, 32'h8000_0000), 1,
            bone_out(0, 32'h0002_0000, 32'h0002_0000, 1));
    // Budget shrinks by a quarter at the layer change
    add_row(trk(7, 16384, 1, 0, 32'h0004_0000), 0, '0);
    add_row(trk(6, 65536, 1, 1, 32'h0001_0000), 0, '0);
    // Same layer three times: accumulators and layer total saturate, then stop
    add_row(trk(3, 65536, 1, 0, 32'h7FFF_FFFF), 0, '0);
    add_row(trk(3, 65536, 1, 0, 32'h7FFF_FFFF), 0, '0);
    add_row(trk(3, 65536, 1, 0, 32'h7FFF_FFFF), 0, '0);
    add_row(trk(2, 65536, 1, 1, 32'h0000_0000), 0, '0);
    // Negative saturation
    add_row(trk(255, 65536, 1, 0, 32'h8000_0000), 0, '0);
    add_row(trk(255, 65536, 1, 1, 32'h8000_0000), 0, '0);
    // Disabled and zero-weight tracks inside a bone
    add_row(trk(10, 32768, 0, 0, 32'h0005_0000), 0, '0);
    add_row(trk(9, 32768, 1, 0, 32'h0003_8000), 0, '0);
    add_row(trk(9, 0, 1, 0, 32'h7FFF_0000), 0, '0);
    add_row(trk(8, 131071, 1, 1, 32'hFFFF_0000), 0, '0);
    // Layers arriving out of order
    add_row(trk(2, 12288, 1, 0, 32'h1234_5678), 0, '0);
    add_row(trk(7, 20480, 1, 0, 32'hEDCB_A988), 0, '0);
    add_row(trk(7, 1, 1, 1, 32'h0000_0001), 0, '0);
    // Lone disabled track at half weight
    add_row(trk(1, 32768, 0, 1, 32'hFFFC_0000), 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) send_track(script[k].trk, script[k].typed, script[k].res);

    // Random bones: mostly descending layers, some jumps, varied run lengths.
    hold_sink = 1'b1;
    sent = 0;
    while (sent < RAND_TRACKS) begin
      run_len     = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      lyr         = $urandom_range(255);
      src_steady  = ($urandom_range(5) == 0);
      sink_steady = ($urandom_range(5) == 0);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(7) == 0)
          lyr = $urandom_range(255);
        else if (k > 0 && $urandom_range(1) == 1)
          lyr = lyr - int'($urandom_range(lyr < 4 ? lyr : 4));
        t = '0;
        cw_pick          = rand_weight();
        t.layer          = lyr[lwtb_pkg::LAYER_W-1:0];
        t.current_weight = cw_pick[lwtb_pkg::WGT_W-1:0];
        t.blend_enabled  = ($urandom_range(7) != 0);
        for (int i = 0; i < lwtb_pkg::NUM_CH; i++) t.vals[i] = rand_word();
        t.last = (k == run_len - 1);
        send_track(t, 1'b0, '0);
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every pending result, then watch for stray transactions.
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/lwtb_pkg.sv
rtl/lwtb_ctrl.sv
rtl/lwtb_datapath.sv
rtl/layered_weighted_transform_blend.sv
rtl/lwtb_checker.sv
sim/tb_layered_weighted_transform_blend.sv
